// File: hdl/atmm_pkg.sv
// Shared constants, types and register indexes for the ADC trimmed mean monitor.
package atmm_pkg;

    localparam int ADC_BITS    = 12;
    localparam int WINDOW      = 10;
    localparam int SLOT_W      = $clog2(WINDOW);
    localparam int TEMP_SLOTS  = 8;
    localparam int TRIM_SHIFT  = 3;
    localparam int SUM_W       = ADC_BITS + $clog2(WINDOW);
    localparam int AVG_W       = SUM_W - TRIM_SHIFT;
    localparam int TSUM_W      = ADC_BITS + $clog2(TEMP_SLOTS);
    localparam int VAL_W       = 16;
    localparam int ERR_W       = 12;
    localparam int MUL_W       = 17;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int GAIN_FRAC   = 8;
    localparam int DIV5_SHIFT  = 18;
    localparam int TEMP_MAX    = 32767;
    localparam int TEMP_MIN    = -32768;
    localparam int TEMP_FLOOR  = 16;

    localparam logic [MUL_W-1:0] DIV5_RECIP = 17'd52429;
    localparam logic [VAL_W-1:0] SAT16      = 16'hFFFF;

    typedef logic [2:0] cfg_index_t;
    localparam cfg_index_t REG_CURRENT_GAIN  = 3'd0;
    localparam cfg_index_t REG_VOLTAGE_GAIN  = 3'd1;
    localparam cfg_index_t REG_TEMP_SLOPE    = 3'd2;
    localparam cfg_index_t REG_TEMP_OFFSET   = 3'd3;
    localparam cfg_index_t REG_CURRENT_FLOOR = 3'd4;
    localparam cfg_index_t REG_VOLTAGE_FLOOR = 3'd5;

    typedef logic [ADC_BITS-1:0] sample_t;
    typedef logic [SLOT_W-1:0]   slot_t;

    typedef struct packed {
        sample_t cur;
        sample_t bat;
        sample_t err;
        sample_t tmp;
    } ring_entry_t;

    typedef struct packed {
        logic clear;
        logic en;
        logic temp_en;
    } acc_ctrl_t;

    typedef struct packed {
        logic [AVG_W-1:0] avg_cur;
        logic [AVG_W-1:0] avg_bat;
        logic [AVG_W-1:0] avg_err;
        sample_t          tavg;
    } acc_result_t;

endpackage

// File: hdl/atmm_ring.sv
// Ten-slot sample ring: one write port, one read port indexed by the walk counter.
module atmm_ring (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  atmm_pkg::slot_t       wr_slot,
    input  atmm_pkg::ring_entry_t wr_data,
    input  atmm_pkg::slot_t       rd_slot,
    output atmm_pkg::ring_entry_t rd_data
);
    import atmm_pkg::*;

    ring_entry_t ring_reg [WINDOW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            ring_reg[wr_slot] <= wr_data;
        end
    end

    assign rd_data = ring_reg[rd_slot];

endmodule

// File: hdl/atmm_accum.sv
// Per-channel sums while the ring is walked; min and max but not for temp.
module atmm_accum (
    input  logic                  clk,
    input  logic                  rst_n,
    input  atmm_pkg::acc_ctrl_t   ctrl,
    input  atmm_pkg::ring_entry_t entry,
    output atmm_pkg::acc_result_t result
);
    import atmm_pkg::*;

    logic [SUM_W-1:0]  sum_reg [3];
    sample_t           min_reg [3];
    sample_t           max_reg [3];
    logic [TSUM_W-1:0] tsum_reg;
    sample_t           chan [3];
    logic [SUM_W-1:0]  trim [3];

    assign chan[0] = entry.cur;
    assign chan[1] = entry.bat;
    assign chan[2] = entry.err;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 3; c++)
            begin
                sum_reg[c] <= '0;
                min_reg[c] <= '1;
                max_reg[c] <= '0;
            end
            tsum_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            for (int c = 0; c < 3; c++)
            begin
                sum_reg[c] <= '0;
                min_reg[c] <= '1;
                max_reg[c] <= '0;
            end
            tsum_reg <= '0;
        end
        else if (ctrl.en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                sum_reg[c] <= sum_reg[c] + SUM_W'(chan[c]);
                if (chan[c] < min_reg[c])
                begin
                    min_reg[c] <= chan[c];
                end
                if (chan[c] > max_reg[c])
                begin
                    max_reg[c] <= chan[c];
                end
            end
            if (ctrl.temp_en)
            begin
                tsum_reg <= tsum_reg + TSUM_W'(entry.tmp);
            end
        end
    end

    // after a full walk the sum covers its own min and max, so no underflow
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            trim[c] = sum_reg[c] - SUM_W'(min_reg[c]) - SUM_W'(max_reg[c]);
        end
    end

    assign result.avg_cur = trim[0][SUM_W-1:TRIM_SHIFT];
    assign result.avg_bat = trim[1][SUM_W-1:TRIM_SHIFT];
    assign result.avg_err = trim[2][SUM_W-1:TRIM_SHIFT];
    assign result.tavg    = tsum_reg[TSUM_W-1:$clog2(TEMP_SLOTS)];

endmodule

// File: hdl/atmm_mul.sv
// Shared signed multiplier with a registered product.
module atmm_mul (
    input  logic                                 clk,
    input  logic signed [atmm_pkg::MUL_W-1:0]    a,
    input  logic signed [atmm_pkg::MUL_W-1:0]    b,
    output logic signed [atmm_pkg::PROD_W-1:0]   prod
);
    import atmm_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// File: hdl/adc_trimmed_mean_monitor.sv
// Each accepted request walks the sample ring, then passes through the single shared
// multiplier and an output load; sample_stall stays high until the block returns to idle,
// so a new request is taken only after the last one is loaded into the output register.
// A finished result may wait in the output register while the next request runs.
// Reset (async, active low) zeroes the ring and write slot, loads register
// defaults and drops result_valid.
module adc_trimmed_mean_monitor (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  logic [atmm_pkg::ADC_BITS-1:0]  sample_current,
    input  logic [atmm_pkg::ADC_BITS-1:0]  sample_battery,
    input  logic [atmm_pkg::ADC_BITS-1:0]  sample_error,
    input  logic [atmm_pkg::ADC_BITS-1:0]  sample_temp,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [15:0]                    current_value,
    output logic [15:0]                    battery_voltage,
    output logic [11:0]                    error_voltage,
    output logic signed [15:0]             temperature,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  atmm_pkg::cfg_index_t           cfg_index,
    input  logic [15:0]                    cfg_data
);
    import atmm_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_MUL, ST_HOLD} state_t;

    state_t state_reg, state_next;
    slot_t  wslot_reg, wslot_next;
    slot_t  rslot_reg, rslot_next;
    logic [2:0] step_reg, step_next;

    logic [VAL_W-1:0] current_gain_reg, voltage_gain_reg;
    logic [VAL_W-1:0] temp_slope_reg, temp_offset_reg;
    logic [VAL_W-1:0] current_floor_reg, voltage_floor_reg;

    logic [VAL_W-1:0] cur_reg, cur_next;
    logic [VAL_W-1:0] bat_reg, bat_next;
    logic [VAL_W-1:0] errs_reg, errs_next;
    logic [ERR_W-1:0] err_reg, err_next;
    logic [VAL_W-1:0] tmp_reg, tmp_next;

    logic             rvalid_reg, rvalid_next;
    logic [VAL_W-1:0] ocur_reg, ocur_next;
    logic [VAL_W-1:0] obat_reg, obat_next;
    logic [ERR_W-1:0] oerr_reg, oerr_next;
    logic [VAL_W-1:0] otmp_reg, otmp_next;

    logic        accept;
    ring_entry_t wr_data, rd_data;
    acc_ctrl_t   acc_ctrl;
    acc_result_t acc;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;

    logic [VAL_W-1:0]         scaled;
    logic signed [PROD_W-1:0] tv;
    logic signed [PROD_W-9:0] tq;
    logic signed [VAL_W-1:0]  tsat;
    logic [ERR_W-1:0]         err_q;

    assign accept       = sample_valid && (state_reg == ST_IDLE);
    assign sample_stall = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;

    assign wr_data.cur = sample_current;
    assign wr_data.bat = sample_battery;
    assign wr_data.err = sample_error;
    assign wr_data.tmp = sample_temp;

    assign acc_ctrl.clear   = accept;
    assign acc_ctrl.en      = (state_reg == ST_WALK);
    assign acc_ctrl.temp_en = (32'(rslot_reg) < TEMP_SLOTS);

    atmm_ring u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_slot (wslot_reg),
        .wr_data (wr_data),
        .rd_slot (rslot_reg),
        .rd_data (rd_data)
    );

    atmm_accum u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (acc_ctrl),
        .entry  (rd_data),
        .result (acc)
    );

    atmm_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            3'd0:
            begin
                mul_a = {{(MUL_W-AVG_W){1'b0}}, acc.avg_cur};
                mul_b = {1'b0, current_gain_reg};
            end
            3'd1:
            begin
                mul_a = {{(MUL_W-AVG_W){1'b0}}, acc.avg_bat};
                mul_b = {1'b0, voltage_gain_reg};
            end
            3'd2:
            begin
                mul_a = {{(MUL_W-AVG_W){1'b0}}, acc.avg_err};
                mul_b = {1'b0, voltage_gain_reg};
            end
            3'd3:
            begin
                mul_a = {temp_slope_reg[VAL_W-1], temp_slope_reg};
                mul_b = {{(MUL_W-ADC_BITS){1'b0}}, acc.tavg};
            end
            3'd4:
            begin
                // x/20 = (x>>2)/5, the /5 by reciprocal
                mul_a = {3'b000, errs_reg[VAL_W-1:2]};
                mul_b = DIV5_RECIP;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // post-processing of the previous product
    always_comb
    begin
        if (|prod[PROD_W-1:VAL_W+GAIN_FRAC])
        begin
            scaled = SAT16;
        end
        else
        begin
            scaled = prod[VAL_W+GAIN_FRAC-1:GAIN_FRAC];
        end

        tv = prod + {{(PROD_W-VAL_W-8){temp_offset_reg[VAL_W-1]}}, temp_offset_reg, 8'h00};
        tq = tv[PROD_W-1:8];
        if (tq > TEMP_MAX)
        begin
            tsat = 16'sh7FFF;
        end
        else if (tq < TEMP_MIN)
        begin
            tsat = 16'sh8000;
        end
        else
        begin
            tsat = tq[VAL_W-1:0];
        end

        err_q = prod[DIV5_SHIFT +: ERR_W];
    end

    always_comb
    begin
        state_next  = state_reg;
        wslot_next  = wslot_reg;
        rslot_next  = rslot_reg;
        step_next   = step_reg;
        cur_next    = cur_reg;
        bat_next    = bat_reg;
        errs_next   = errs_reg;
        err_next    = err_reg;
        tmp_next    = tmp_reg;
        rvalid_next = rvalid_reg && result_stall;
        ocur_next   = ocur_reg;
        obat_next   = obat_reg;
        oerr_next   = oerr_reg;
        otmp_next   = otmp_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (32'(wslot_reg) >= WINDOW - 1)
                    begin
                        wslot_next = '0;
                    end
                    else
                    begin
                        wslot_next = wslot_reg + 1'b1;
                    end
                    rslot_next = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (32'(rslot_reg) == WINDOW - 1)
                begin
                    rslot_next = '0;
                    step_next  = '0;
                    state_next = ST_MUL;
                end
                else
                begin
                    rslot_next = rslot_reg + 1'b1;
                end
            end
            ST_MUL:
            begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    3'd1:
                    begin
                        cur_next = (scaled < current_floor_reg) ? '0 : scaled;
                    end
                    3'd2:
                    begin
                        bat_next = (scaled <= voltage_floor_reg) ? '0 : scaled;
                    end
                    3'd3:
                    begin
                        errs_next = scaled;
                    end
                    3'd4:
                    begin
                        tmp_next = (tsat <= TEMP_FLOOR) ? '0 : tsat;
                    end
                    3'd5:
                    begin
                        err_next   = ({4'b0000, err_q} <= voltage_floor_reg) ? '0 : err_q;
                        step_next  = '0;
                        state_next = ST_HOLD;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_HOLD:
            begin
                if (!rvalid_reg || !result_stall)
                begin
                    rvalid_next = 1'b1;
                    ocur_next   = cur_reg;
                    obat_next   = bat_reg;
                    oerr_next   = err_reg;
                    otmp_next   = tmp_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            wslot_reg         <= '0;
            rslot_reg         <= '0;
            step_reg          <= '0;
            rvalid_reg        <= 1'b0;
            cur_reg           <= '0;
            bat_reg           <= '0;
            errs_reg          <= '0;
            err_reg           <= '0;
            tmp_reg           <= '0;
            ocur_reg          <= '0;
            obat_reg          <= '0;
            oerr_reg          <= '0;
            otmp_reg          <= '0;
            current_gain_reg  <= 16'd256;
            voltage_gain_reg  <= 16'd256;
            temp_slope_reg    <= 16'd4096;
            temp_offset_reg   <= 16'd0;
            current_floor_reg <= 16'd10;
            voltage_floor_reg <= 16'd10;
        end
        else
        begin
            state_reg  <= state_next;
            wslot_reg  <= wslot_next;
            rslot_reg  <= rslot_next;
            step_reg   <= step_next;
            rvalid_reg <= rvalid_next;
            cur_reg    <= cur_next;
            bat_reg    <= bat_next;
            errs_reg   <= errs_next;
            err_reg    <= err_next;
            tmp_reg    <= tmp_next;
            ocur_reg   <= ocur_next;
            obat_reg   <= obat_next;
            oerr_reg   <= oerr_next;
            otmp_reg   <= otmp_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_CURRENT_GAIN:  current_gain_reg  <= cfg_data;
                    REG_VOLTAGE_GAIN:  voltage_gain_reg  <= cfg_data;
                    REG_TEMP_SLOPE:    temp_slope_reg    <= cfg_data;
                    REG_TEMP_OFFSET:   temp_offset_reg   <= cfg_data;
                    REG_CURRENT_FLOOR: current_floor_reg <= cfg_data;
                    REG_VOLTAGE_FLOOR: voltage_floor_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign result_valid    = rvalid_reg;
    assign current_value   = ocur_reg;
    assign battery_voltage = obat_reg;
    assign error_voltage   = oerr_reg;
    assign temperature     = otmp_reg;

endmodule

// File: tb/atmm_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the ADC trimmed mean monitor: reading predictor and queue of expected readings.
package atmm_tb_pkg;
    import atmm_pkg::*;

    localparam int ERR_DIVISOR = 20;
    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [15:0]        current;
        logic [15:0]        battery;
        logic [11:0]        err_volt;
        logic signed [15:0] temp;
    } reading_t;

    class telemetry_scoreboard;
        ring_entry_t ring[WINDOW];
        int unsigned next_slot;
        logic [15:0] current_gain;
        logic [15:0] voltage_gain;
        logic [15:0] temp_slope;
        logic [15:0] temp_offset;
        logic [15:0] current_floor;
        logic [15:0] voltage_floor;
        reading_t    expected_readings[$];
        int unsigned errors;

        function new();
            foreach (ring[i])
                ring[i] = '0;
            next_slot     = 0;
            current_gain  = 16'd256;
            voltage_gain  = 16'd256;
            temp_slope    = 16'd4096;
            temp_offset   = 16'd0;
            current_floor = 16'd10;
            voltage_floor = 16'd10;
            errors        = 0;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        function void write_reg(cfg_index_t idx, logic [15:0] data);
            case (idx)
                REG_CURRENT_GAIN:  current_gain  = data;
                REG_VOLTAGE_GAIN:  voltage_gain  = data;
                REG_TEMP_SLOPE:    temp_slope    = data;
                REG_TEMP_OFFSET:   temp_offset   = data;
                REG_CURRENT_FLOOR: current_floor = data;
                REG_VOLTAGE_FLOOR: voltage_floor = data;
                default: ;
            endcase
        endfunction

        // drop min and max of the window, average the other eight, scale and clip
        function longint scaled_trim(sample_t vals[WINDOW], logic [15:0] gain);
            longint total;
            longint lo;
            longint hi;
            longint prod;
            total = 0;
            lo    = SAT16;
            hi    = 0;
            foreach (vals[i]) begin
                total += vals[i];
                if (vals[i] < lo) lo = vals[i];
                if (vals[i] > hi) hi = vals[i];
            end
            prod = (((total - lo - hi) >> TRIM_SHIFT) * longint'(gain)) >> GAIN_FRAC;
            return (prod > longint'(SAT16)) ? longint'(SAT16) : prod;
        endfunction

        function reading_t predict_reading(sample_t cur, sample_t bat, sample_t errs,
                                           sample_t tmp);
            sample_t  cur_v[WINDOW];
            sample_t  bat_v[WINDOW];
            sample_t  err_v[WINDOW];
            reading_t r;
            longint   c;
            longint   b;
            longint   e;
            longint   t;
            longint   tsum;
            int       i;
            ring[next_slot] = {cur, bat, errs, tmp};
            next_slot = (next_slot + 1) % WINDOW;
            tsum = 0;
            for (i = 0; i < WINDOW; i++) begin
                cur_v[i] = ring[i].cur;
                bat_v[i] = ring[i].bat;
                err_v[i] = ring[i].err;
                if (i < TEMP_SLOTS)
                    tsum += ring[i].tmp;
            end
            c = scaled_trim(cur_v, current_gain);
            if (c < current_floor) c = 0;
            b = scaled_trim(bat_v, voltage_gain);
            if (b <= voltage_floor) b = 0;
            // floor test on error voltage comes after the divide
            e = scaled_trim(err_v, voltage_gain) / ERR_DIVISOR;
            if (e <= voltage_floor) e = 0;
            // arithmetic shift gives floor toward minus infinity
            t = (longint'($signed(temp_slope)) * (tsum >> TRIM_SHIFT)
                 + (longint'($signed(temp_offset)) <<< GAIN_FRAC)) >>> GAIN_FRAC;
            if (t > TEMP_MAX) t = TEMP_MAX;
            if (t < TEMP_MIN) t = TEMP_MIN;
            if (t <= TEMP_FLOOR) t = 0;
            r.current  = c[15:0];
            r.battery  = b[15:0];
            r.err_volt = e[11:0];
            r.temp     = t[15:0];
            return r;
        endfunction

        function void note_request(sample_t cur, sample_t bat, sample_t errs, sample_t tmp);
            expected_readings.push_back(predict_reading(cur, bat, errs, tmp));
        endfunction

        task check_result(reading_t got);
            reading_t want;
            if (expected_readings.size() == 0) begin
                report($sformatf("result with none expected: %0d %0d %0d %0d", got.current,
                                 got.battery, got.err_volt, $signed(got.temp)));
                return;
            end
            want = expected_readings.pop_front();
            if (got.current !== want.current)
                report($sformatf("current_value got %0d expected %0d",
                                 got.current, want.current));
            if (got.battery !== want.battery)
                report($sformatf("battery_voltage got %0d expected %0d",
                                 got.battery, want.battery));
            if (got.err_volt !== want.err_volt)
                report($sformatf("error_voltage got %0d expected %0d",
                                 got.err_volt, want.err_volt));
            if (got.temp !== want.temp)
                report($sformatf("temperature got %0d expected %0d",
                                 $signed(got.temp), $signed(want.temp)));
        endtask

        function int unsigned pending();
            return expected_readings.size();
        endfunction

        task check_drained();
            if (expected_readings.size() != 0)
                report($sformatf("%0d expected results never arrived",
                                 expected_readings.size()));
        endtask
    endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench for the ADC trimmed mean monitor.
module tb_top;
    import atmm_pkg::*;
    import atmm_tb_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS   = 248;
    localparam cfg_index_t REG_SPARE_A = 3'd6;
    localparam cfg_index_t REG_SPARE_B = 3'd7;

    logic        clk             = 1'b0;
    logic        rst_n           = 1'b0;
    logic        sample_valid    = 1'b0;
    logic        sample_stall;
    sample_t     sample_current  = '0;
    sample_t     sample_battery  = '0;
    sample_t     sample_error    = '0;
    sample_t     sample_temp     = '0;
    logic        result_valid;
    logic        result_stall    = 1'b0;
    logic [15:0] current_value;
    logic [15:0] battery_voltage;
    logic [11:0] error_voltage;
    logic signed [15:0] temperature;
    logic        cfg_valid       = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index       = REG_CURRENT_GAIN;
    logic [15:0] cfg_data        = '0;

    telemetry_scoreboard board;
    int unsigned quiet_cycles  = 0;
    int unsigned readings_sent = 0;
    int unsigned rx_hold_left  = 0;
    int unsigned rx_burst_left = 0;
    bit          tx_jitter     = 1'b1;
    bit          rx_jitter     = 1'b1;
    sample_t     last_cur      = '0;
    sample_t     last_bat      = '0;
    sample_t     last_err      = '0;
    sample_t     last_tmp      = '0;

    adc_trimmed_mean_monitor uut (.*);

    always #(CLK_PERIOD / 2) clk = ~clk;

    // all handshakes sampled at the edge, before any update of that step lands
    always @(posedge clk) begin
        if (rst_n) begin
            if (sample_valid && !sample_stall)
                board.note_request(sample_current, sample_battery, sample_error, sample_temp);
            if (result_valid && !result_stall)
                board.check_result({current_value, battery_voltage, error_voltage,
                                    temperature});
            if (cfg_valid && cfg_ready)
                board.write_reg(cfg_index, cfg_data);
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: long hold-off when asked, else random stall bursts while rx_jitter is set
    initial begin
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (rx_hold_left != 0) begin
                rx_hold_left--;
                result_stall <= 1'b1;
            end
            else if (rx_burst_left != 0) begin
                rx_burst_left--;
                result_stall <= 1'b1;
            end
            else if (rx_jitter && $urandom_range(0, 7) == 0) begin
                rx_burst_left = $urandom_range(0, 5);
                result_stall <= 1'b1;
            end
            else begin
                result_stall <= 1'b0;
            end
        end
    end

    task automatic send_reading(input sample_t cur, input sample_t bat, input sample_t errs,
                                input sample_t tmp);
        if (tx_jitter && $urandom_range(0, 5) == 0) begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        sample_valid   <= 1'b1;
        sample_current <= cur;
        sample_battery <= bat;
        sample_error   <= errs;
        sample_temp    <= tmp;
        do @(posedge clk); while (sample_stall);
        last_cur = cur;
        last_bat = bat;
        last_err = errs;
        last_tmp = tmp;
        readings_sent++;
    endtask

    // sender pauses until every request has produced its result
    task automatic drain_readings();
        sample_valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings(input logic [15:0] cgain, input logic [15:0] vgain,
                                 input logic [15:0] slope, input logic [15:0] offset,
                                 input logic [15:0] cfloor, input logic [15:0] vfloor,
                                 input bit spare);
        cfg_index_t  idx[$];
        logic [15:0] val[$];
        idx = '{REG_CURRENT_GAIN, REG_VOLTAGE_GAIN, REG_TEMP_SLOPE, REG_TEMP_OFFSET,
                REG_CURRENT_FLOOR, REG_VOLTAGE_FLOOR};
        val = '{cgain, vgain, slope, offset, cfloor, vfloor};
        if (spare) begin
            // unmapped indexes must leave everything alone
            idx.push_back(REG_SPARE_A);
            val.push_back(16'($urandom));
            idx.push_back(REG_SPARE_B);
            val.push_back(16'($urandom));
        end
        foreach (idx[i]) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(128, 512));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_floor();
        case ($urandom_range(0, 7))
            0:          return 16'd0;
            1:          return 16'hFFFF;
            2, 3, 4, 5: return 16'($urandom_range(0, 300));
            default:    return 16'($urandom);
        endcase
    endfunction

    task automatic load_random_settings();
        logic [15:0] slope;
        logic [15:0] offset;
        if ($urandom_range(0, 2) != 0) begin
            slope  = 16'($urandom_range(0, 12288)) - 16'd4096;
            offset = 16'($urandom_range(0, 1024)) - 16'd512;
        end
        else begin
            slope  = 16'($urandom);
            offset = 16'($urandom);
        end
        load_settings(pick_gain(), pick_gain(), slope, offset, pick_floor(), pick_floor(),
                      1'($urandom_range(0, 1)));
    endtask

    function automatic sample_t pick_sample(int mode);
        if (mode < 9)
            return sample_t'($urandom_range(0, 300));
        else if (mode < 12)
            return sample_t'($urandom_range(3800, 4095));
        else if (mode == 12)
            return ($urandom_range(0, 1) != 0) ? '1 : '0;
        else
            return sample_t'($urandom);
    endfunction

    task automatic send_random_reading();
        int mode;
        mode = $urandom_range(0, 19);
        // repeated samples make the trimmed mean land on exact values
        if (mode == 0)
            repeat (WINDOW) send_reading(last_cur, last_bat, last_err, last_tmp);
        else if (mode < 4)
            send_reading(last_cur, last_bat, last_err, last_tmp);
        else
            send_reading(pick_sample(mode), pick_sample(mode), pick_sample(mode),
                         pick_sample(mode));
    endtask

    initial begin
        int          phase;
        int unsigned phase_end;
        bit          held;
        board = new();
        held  = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults, zeroed ring
        send_reading('0, '0, '0, '0);
        send_reading('1, '1, '1, '1);
        send_reading(12'hAAA, 12'h555, 12'hAAA, 12'h555);
        send_reading(12'd1, 12'd4094, 12'd0, 12'd4095);
        drain_readings();

        // steady ring right at the floors; temperature crosses the 1.0 degree cutoff
        load_settings(16'd256, 16'd256, 16'd4096, 16'd1, 16'd100, 16'd100, 1'b0);
        repeat (WINDOW) send_reading(12'd100, 12'd100, 12'd2020, 12'd1);
        drain_readings();

        // max gains, zero floors: saturation, negative temperature clip
        load_settings(16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'd0, 16'd0, 1'b1);
        repeat (3) send_reading('1, '1, '1, '1);
        drain_readings();

        // zero gains, max floors, positive temperature clip
        load_settings(16'd0, 16'd0, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 1'b1);
        send_reading('0, '0, '0, '0);
        repeat (2) send_reading('1, '1, '1, '1);

        phase_end = readings_sent;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == RANDOM_PHASES - 1) begin
                tx_jitter = 1'b0;
                rx_jitter = 1'b0;
            end
            drain_readings();
            load_random_settings();
            phase_end += PHASE_ITEMS;
            while (readings_sent < phase_end) begin
                // hold results off long enough that the block backs up its input
                if (phase == 2 && !held && readings_sent >= phase_end - PHASE_ITEMS / 2) begin
                    held = 1'b1;
                    rx_hold_left = HOLD_CYCLES;
                end
                send_random_reading();
            end
        end

        drain_readings();
        board.check_drained();
        if (board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
hdl/atmm_pkg.sv
hdl/atmm_ring.sv
hdl/atmm_accum.sv
hdl/atmm_mul.sv
hdl/adc_trimmed_mean_monitor.sv
tb/atmm_tb_pkg.sv
tb/tb_top.sv
